FILE: design/integer_to_radix_ascii_macros.svh
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

// Clocked assertion, quiet while rst_n is low.
`define IRX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that must also hold across reset.
`define IRX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/irx_pkg.sv
package irx_pkg;

  localparam int IN_W       = 32;
  localparam int RADIX_W    = 8;
  localparam int RDIV_W     = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 7;
  localparam int STEP_BITS  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 8'd16;

  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 7'd55;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } irx_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } irx_q_stat_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    if (d < DECIMAL_LIMIT) begin
      return CHAR_W'(d) + ASCII_ZERO;
    end
    return CHAR_W'(d) + LETTER_OFFSET;
  endfunction

endpackage

FILE: design/irx_in_if.sv
interface irx_in_if;
  logic                     valid;
  logic                     ready;
  logic [irx_pkg::IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: design/irx_out_if.sv
interface irx_out_if;
  logic                       valid;
  logic                       ready;
  logic [irx_pkg::CHAR_W-1:0] digit_char;
  logic                       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

FILE: design/irx_front.sv
module irx_front #(
  parameter int OPW = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  irx_in_if.sink                        in_ch,
  input  logic                          cfg_we,
  input  logic [irx_pkg::RADIX_W-1:0]   cfg_wdata,
  input  irx_pkg::irx_q_stat_t          q_stat,
  output logic                          push,
  output logic [OPW-1:0]                push_value,
  output logic [irx_pkg::RDIV_W-1:0]    push_radix
);
  import irx_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic               radix_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  assign radix_ok    = (radix_r >= RADIX_MIN) && (radix_r <= RADIX_MAX);
  assign in_ch.ready = !q_stat.full;

  // Drop items under an illegal base: they are taken but never queued.
  assign push       = in_ch.valid && in_ch.ready && radix_ok;
  assign push_value = in_ch.value[OPW-1:0];
  assign push_radix = radix_r[RDIV_W-1:0];

endmodule

FILE: design/irx_queue.sv
module irx_queue #(
  parameter int W = 37
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [W-1:0]         push_data,
  input  logic                 pop,
  output logic [W-1:0]         pop_data,
  output irx_pkg::irx_q_stat_t q_stat
);
  import irx_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [W-1:0]  mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign q_stat.full  = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/irx_back.sv
module irx_back #(
  parameter int OPW = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  irx_pkg::irx_q_stat_t        q_stat,
  input  logic [OPW-1:0]              pop_value,
  input  logic [irx_pkg::RDIV_W-1:0]  pop_radix,
  output logic                        pop,
  irx_out_if.source                   out_ch
);
  import irx_pkg::*;

  localparam int NSTEP = (OPW + STEP_BITS - 1) / STEP_BITS;
  localparam int DW    = NSTEP * STEP_BITS;
  localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int IW    = $clog2(OPW);

  irx_state_t          state_r;
  logic [DW-1:0]       dvd_r;
  logic [DIGIT_W-1:0]  rem_r;
  logic [RDIV_W-1:0]   rad_r;
  logic [SW-1:0]       step_r;
  logic [IW-1:0]       cnt_r;
  logic [IW-1:0]       idx_r;
  logic [DIGIT_W-1:0]  stack_r [OPW];
  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;

  logic [DW-1:0]       dvd_step;
  logic [DIGIT_W-1:0]  rem_step;
  logic                step_last;
  logic                q_zero;
  logic                out_load;

  // Eight restoring-division steps: quotient bits shift in at the bottom.
  always_comb begin
    logic [RDIV_W-1:0] t;
    rem_step = rem_r;
    dvd_step = dvd_r;
    for (int i = 0; i < STEP_BITS; i++) begin
      t        = {rem_step, dvd_step[DW-1]};
      dvd_step = {dvd_step[DW-2:0], 1'b0};
      if (t >= rad_r) begin
        rem_step    = DIGIT_W'(t - rad_r);
        dvd_step[0] = 1'b1;
      end else begin
        rem_step = t[DIGIT_W-1:0];
      end
    end
  end

  assign step_last = (step_r == SW'(NSTEP - 1));
  assign q_zero    = (dvd_step == '0);
  assign pop       = (state_r == ST_IDLE) && !q_stat.empty;
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.last_digit = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_last && q_zero) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load && (idx_r == '0)) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          dvd_r  <= DW'(pop_value);
          rad_r  <= pop_radix;
          rem_r  <= '0;
          step_r <= '0;
          cnt_r  <= '0;
        end
      end
      ST_DIV: begin
        dvd_r <= dvd_step;
        if (step_last) begin
          // Push the digit, then restart on the quotient.
          stack_r[cnt_r] <= rem_step;
          cnt_r          <= cnt_r + 1'b1;
          idx_r          <= cnt_r;
          rem_r          <= '0;
          step_r         <= '0;
        end else begin
          rem_r  <= rem_step;
          step_r <= step_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_char_r <= to_ascii(stack_r[idx_r]);
          out_last_r <= (idx_r == '0);
          idx_r      <= idx_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/integer_to_radix_ascii.sv
// Converts each unsigned input value into its ASCII digits in the base held
// in the radix register (2..16, reset 10), most significant digit first,
// one character per output transfer, with last_digit set on the final one.
// Zero gives a single '0'. While radix is outside 2..16 input transfers are
// still taken but produce no characters. Only the low VALUE_WIDTH bits of
// value are used (at most 32). The divider yields 8 quotient bits a cycle;
// once the quotient reaches zero the stacked digits are emitted at one per
// cycle while the receiver is ready. A two-entry queue sits in front of the
// divider, so up to two more items are taken while one is being converted.
module integer_to_radix_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  irx_in_if.sink                       in_ch,
  irx_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [irx_pkg::RADIX_W-1:0]  cfg_wdata
);
  import irx_pkg::*;

  // Width actually converted: the value port carries 32 bits.
  localparam int OPW = (VALUE_WIDTH < IN_W) ? VALUE_WIDTH : IN_W;
  localparam int QW  = OPW + RDIV_W;

  irx_q_stat_t         q_stat;
  logic                push;
  logic [OPW-1:0]      push_value;
  logic [RDIV_W-1:0]   push_radix;
  logic                pop;
  logic [QW-1:0]       pop_data;

  // Front end: hold the radix register, accept and classify items.
  irx_front #(.OPW(OPW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_value (push_value),
    .push_radix (push_radix)
  );

  // Each entry carries the masked value and the base it was accepted under.
  irx_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_radix, push_value}),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // Back end: divide into a digit stack, then drain it top-down.
  irx_back #(.OPW(OPW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_value (pop_data[OPW-1:0]),
    .pop_radix (pop_data[QW-1:OPW]),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: design/irx_checker.sv
`include "integer_to_radix_ascii_macros.svh"

module irx_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [irx_pkg::CHAR_W-1:0] digit_char,
  input logic                       last_digit
);
  import irx_pkg::*;

  `IRX_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output valid dropped while stalled")
  `IRX_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(digit_char) && $stable(last_digit), "stalled output changed")
  `IRX_ASSERT(a_char_legal, out_valid |-> (digit_char >= 7'd48 && digit_char <= 7'd57) || (digit_char >= 7'd65 && digit_char <= 7'd70), "output char is not a base-16 digit")
  `IRX_ASSERT_ALWAYS(a_reset_quiet, $past(!rst_n) |-> !out_valid, "output valid right after reset")

endmodule

bind integer_to_radix_ascii irx_checker u_irx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .digit_char (out_ch.digit_char),
  .last_digit (out_ch.last_digit)
);

FILE: tb/sv/irx_digit_checker.sv
module irx_digit_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  irx_in_if                           in_mon,
  irx_out_if                          out_mon,
  input  logic                        cfg_we,
  input  logic [irx_pkg::RADIX_W-1:0] cfg_wdata,
  output int                          error_count,
  output int                          chars_pending,
  output int                          values_converted,
  output int                          chars_checked
);
  import irx_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              last;
  } digit_char_t;

  digit_char_t        expected_chars[$];
  digit_char_t        want;
  logic [RADIX_W-1:0] radix_shadow;
  logic [IN_W-1:0]    quotient;
  logic [DIGIT_W-1:0] digit_vals[32];
  int                 digit_total;

  initial begin
    error_count      = 0;
    chars_pending    = 0;
    values_converted = 0;
    chars_checked    = 0;
    radix_shadow     = RADIX_RESET;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      radix_shadow = RADIX_RESET;
      expected_chars.delete();
    end else begin
      // Compare each output transfer against the oldest predicted character.
      if (out_mon.valid && out_mon.ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          error_count++;
          $display("%0t: unexpected char: expected none, actual %0d last=%0b",
                   $time, out_mon.digit_char, out_mon.last_digit);
        end else begin
          want = expected_chars.pop_front();
          if (out_mon.digit_char !== want.glyph) begin
            error_count++;
            $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                     $time, want.glyph, out_mon.digit_char);
          end
          if (out_mon.last_digit !== want.last) begin
            error_count++;
            $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                     $time, want.last, out_mon.last_digit);
          end
        end
      end
      // Divide out the digits, least significant first, then queue them msd first.
      if (in_mon.valid && in_mon.ready &&
          radix_shadow >= RADIX_MIN && radix_shadow <= RADIX_MAX) begin
        values_converted++;
        quotient    = in_mon.value;
        digit_total = 0;
        do begin
          digit_vals[digit_total] = DIGIT_W'(quotient % radix_shadow);
          quotient                = quotient / radix_shadow;
          digit_total++;
        end while (quotient != 0);
        for (int k = digit_total - 1; k >= 0; k--) begin
          want.glyph = (digit_vals[k] < DECIMAL_LIMIT)
                     ? CHAR_W'(digit_vals[k]) + ASCII_ZERO
                     : CHAR_W'(digit_vals[k]) + LETTER_OFFSET;
          want.last  = (k == 0);
          expected_chars.push_back(want);
        end
      end
      if (cfg_we) radix_shadow = cfg_wdata;
    end
    chars_pending <= expected_chars.size();
  end

  final begin
    if (expected_chars.size() != 0)
      $display("%0t: %0d predicted chars never arrived", $time, expected_chars.size());
  end

endmodule

FILE: tb/sv/integer_to_radix_ascii_test.sv
module integer_to_radix_ascii_test;
  import irx_pkg::*;

  // Generous ceiling for long binary conversions and output stalls, plus the
  // idle pauses around every radix change.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 600;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PERCENT  = 31;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [RADIX_W-1:0] cfg_wdata;

  int error_count;
  int chars_pending;
  int values_converted;
  int chars_checked;
  int radix_writes;
  int cycle_count;

  // Shared knobs, written only by the stimulus process.
  logic gaps_on;
  logic hold_go;
  // Owned by the receiver process.
  logic hold_done;
  int   hold_left;

  irx_in_if  in_ch();
  irx_out_if out_ch();

  integer_to_radix_ascii dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  irx_digit_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .error_count      (error_count),
    .chars_pending    (chars_pending),
    .values_converted (values_converted),
    .chars_checked    (chars_checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: drop ready at random, and once hold it low for a long stretch
  // so the input queue fills and the block stalls its input side.
  initial begin
    hold_done = 1'b0;
    hold_left = 0;
  end

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (gaps_on) begin
      out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Offer one value, with random idle cycles ahead of it, and hold it until
  // ready reads high.
  task automatic send_value(input logic [IN_W-1:0] v);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Change the base only with the block idle: drain every predicted char,
  // then let the block finish anything that yields no characters.
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radix_writes++;
  endtask

  // Mix of value shapes: full random, short numbers, powers of two, all-ones tails.
  function automatic logic [IN_W-1:0] pick_value();
    logic [IN_W-1:0] v;
    case ($urandom_range(0, 4))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 255);
      2:       v = 32'h1 << $urandom_range(0, 31);
      3:       v = 32'hFFFF_FFFF >> $urandom_range(0, 31);
      default: v = $urandom_range(0, 99999);
    endcase
    return v;
  endfunction

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [RADIX_W-1:0] phase_radix;
    radix_writes = 0;
    gaps_on      = 1'b1;
    hold_go      = 1'b0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset base 10, zero input, single digits, field extremes.
    send_value(32'd0);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFFF);
    // Base 16: every letter digit and the top bit alone.
    set_radix(8'd16);
    send_value(32'hFEDC_BA98);
    send_value(32'h7654_3210);
    send_value(32'h8000_0000);
    send_value(32'd0);
    // Base 2: the 32-digit worst case and the shortest numbers.
    set_radix(8'd2);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd1);
    send_value(32'd0);
    // Bases out of range on both sides, all-zero and all-one register bits:
    // these values must vanish.
    set_radix(8'd0);
    send_value(32'd12345);
    set_radix(8'd1);
    send_value(32'hFFFF_FFFF);
    set_radix(8'd17);
    send_value(32'd0);
    set_radix(8'd255);
    send_value(32'hA5A5_5A5A);
    // Odd bases near the top of each digit count.
    set_radix(8'd3);
    send_value(32'hFFFF_FFFF);
    send_value(32'd2);
    set_radix(8'd15);
    send_value(32'hFFFF_FFFF);
    send_value(32'd14);

    // Random phases. Phase 2 holds the receiver off, phase 5 runs without
    // any idling on either side, phase 8 uses a base that yields nothing.
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 8) phase_radix = RADIX_W'($urandom_range(17, 255));
      else            phase_radix = RADIX_W'($urandom_range(2, 16));
      set_radix(phase_radix);
      gaps_on = (phase != 5);
      if (phase == 2) hold_go = 1'b1;
      for (int i = 0; i < ((phase == 8) ? 6 : 11); i++) send_value(pick_value());
    end
    gaps_on = 1'b1;
    in_ch.valid <= 1'b0;

    // Drain, then give the block time to show any stray characters.
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("converted %0d values, checked %0d digit characters", values_converted,
             chars_checked);
    $display("%0d radix writes, including bases 0, 1, 2, 16, 17 and 255", radix_writes);
    if (error_count == 0 && chars_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: integer_to_radix_ascii.f
+incdir+design
design/irx_pkg.sv
design/irx_in_if.sv
design/irx_out_if.sv
design/irx_front.sv
design/irx_queue.sv
design/irx_back.sv
design/integer_to_radix_ascii.sv
design/irx_checker.sv
tb/sv/irx_digit_checker.sv
tb/sv/integer_to_radix_ascii_test.sv
